[hdl/hsv_pkg.sv]
`default_nettype none

package hsv_pkg;

   // Channel limits and ramp scale factors
   localparam logic [7:0] MAX_CHAN         = 8'd255;
   localparam logic [4:0] RAMP_MASK        = 5'h1F;
   localparam logic [7:0] THIRD_SCALE      = 8'(256 / 3);
   localparam logic [7:0] TWO_THIRDS_SCALE = 8'((256 * 2) / 3);

   // Fixed levels of the rainbow map
   localparam logic [7:0] LEVEL_RISE_TOP = 8'd171;
   localparam logic [7:0] LEVEL_THIRD    = 8'd85;
   localparam logic [7:0] LEVEL_TWO_3RD  = 8'd170;
   localparam logic [7:0] PINK_RED       = 8'd170;
   localparam logic [7:0] PINK_BLUE      = 8'd85;

   // Hue sections, top three hue bits
   localparam logic [2:0] SEC_RED    = 3'd0;
   localparam logic [2:0] SEC_ORANGE = 3'd1;
   localparam logic [2:0] SEC_YELLOW = 3'd2;
   localparam logic [2:0] SEC_GREEN  = 3'd3;
   localparam logic [2:0] SEC_AQUA   = 3'd4;
   localparam logic [2:0] SEC_BLUE   = 3'd5;
   localparam logic [2:0] SEC_PURPLE = 3'd6;
   localparam logic [2:0] SEC_PINK   = 3'd7;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // After the ramp stage
   typedef struct packed {
      logic [2:0] section;
      logic [7:0] third;
      logic [7:0] two_thirds;
      logic [7:0] floor;
      logic       grey;
      logic       full_sat;
      logic [7:0] brightness;
   } ramp_type;

   // After the section map
   typedef struct packed {
      rgb_type    color;
      logic [7:0] floor;
      logic       grey;
      logic       full_sat;
      logic [7:0] brightness;
   } color_type;

   // After desaturation
   typedef struct packed {
      rgb_type    color;
      logic       grey;
      logic [7:0] brightness;
   } shade_type;

endpackage

`default_nettype wire

[hdl/hsv_req_if.sv]
`default_nettype none

interface hsv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] hue;
   logic [7:0] saturation;
   logic [7:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

`default_nettype wire

[hdl/hsv_rsp_if.sv]
`default_nettype none

interface hsv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

[hdl/hsv_ramp_stage.sv]
`default_nettype none

module hsv_ramp_stage
   import hsv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output      logic       in_ready,
   input  wire logic [7:0] hue,
   input  wire logic [7:0] saturation,
   input  wire logic [7:0] brightness,
   output      logic       out_valid,
   input  wire logic       out_ready,
   output      ramp_type   out_data
);

   logic        valid_ff;
   ramp_type    data_ff;
   ramp_type    data_in;
   logic [7:0]  ramp;
   logic [15:0] third_prod;
   logic [15:0] two_prod;
   logic [7:0]  sat_gap;
   logic [15:0] sat_gap_sq;

   // Scale the ramp to thirds and square the saturation distance
   always_comb begin
      ramp       = {hue[4:0] & RAMP_MASK, 3'b000};
      third_prod = ramp * THIRD_SCALE;
      two_prod   = ramp * TWO_THIRDS_SCALE;
      sat_gap    = MAX_CHAN - saturation;
      sat_gap_sq = sat_gap * sat_gap;

      data_in.section    = hue[7:5];
      data_in.third      = third_prod[15:8];
      data_in.two_thirds = two_prod[15:8];
      data_in.floor      = sat_gap_sq[15:8] + 8'd1;
      data_in.grey       = (saturation == 8'd0);
      data_in.full_sat   = (saturation == MAX_CHAN);
      data_in.brightness = brightness;
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance the valid bit when the stage may move
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the payload on an accepted request
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[hdl/hsv_map_stage.sv]
`default_nettype none

module hsv_map_stage
   import hsv_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output      logic      in_ready,
   input  wire ramp_type  in_data,
   output      logic      out_valid,
   input  wire logic      out_ready,
   output      color_type out_data
);

   logic      valid_ff;
   color_type data_ff;
   color_type data_in;
   logic [7:0] t;
   logic [7:0] w;

   // Pick the section color
   always_comb begin
      t = in_data.third;
      w = in_data.two_thirds;
      data_in.floor      = in_data.floor;
      data_in.grey       = in_data.grey;
      data_in.full_sat   = in_data.full_sat;
      data_in.brightness = in_data.brightness;
      case (in_data.section)
         SEC_RED: begin
            data_in.color = '{red: MAX_CHAN - t, green: t, blue: 8'd0};
         end
         SEC_ORANGE: begin
            data_in.color = '{red: LEVEL_RISE_TOP, green: LEVEL_THIRD + t, blue: 8'd0};
         end
         SEC_YELLOW: begin
            data_in.color = '{red: LEVEL_RISE_TOP - w, green: LEVEL_TWO_3RD + t,
                              blue: 8'd0};
         end
         SEC_GREEN: begin
            data_in.color = '{red: 8'd0, green: MAX_CHAN - t, blue: t};
         end
         SEC_AQUA: begin
            data_in.color = '{red: 8'd0, green: LEVEL_RISE_TOP - w, blue: LEVEL_THIRD + t};
         end
         SEC_BLUE: begin
            data_in.color = '{red: t, green: 8'd0, blue: MAX_CHAN - t};
         end
         SEC_PURPLE: begin
            data_in.color = '{red: LEVEL_THIRD + t, green: 8'd0,
                              blue: LEVEL_RISE_TOP - w};
         end
         SEC_PINK: begin
            data_in.color = '{red: PINK_RED, green: 8'd0, blue: PINK_BLUE};
         end
         default: begin
            data_in.color = '{red: 8'd0, green: 8'd0, blue: 8'd0};
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance the valid bit when the stage may move
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the payload on an accepted request
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[hdl/hsv_desat_stage.sv]
`default_nettype none

module hsv_desat_stage
   import hsv_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output      logic      in_ready,
   input  wire color_type in_data,
   output      logic      out_valid,
   input  wire logic      out_ready,
   output      shade_type out_data
);

   logic        valid_ff;
   shade_type   data_ff;
   shade_type   data_in;
   logic [7:0]  keep;
   logic [15:0] red_prod;
   logic [15:0] green_prod;
   logic [15:0] blue_prod;
   logic [7:0]  red_dim;
   logic [7:0]  green_dim;
   logic [7:0]  blue_dim;

   // Scale nonzero channels by the kept share and add the floor; full saturation passes the color unchanged
   always_comb begin
      keep       = MAX_CHAN - in_data.floor;
      red_prod   = in_data.color.red * keep;
      green_prod = in_data.color.green * keep;
      blue_prod  = in_data.color.blue * keep;
      red_dim    = (in_data.color.red == 8'd0) ? 8'd0 : red_prod[15:8] + 8'd1;
      green_dim  = (in_data.color.green == 8'd0) ? 8'd0 : green_prod[15:8] + 8'd1;
      blue_dim   = (in_data.color.blue == 8'd0) ? 8'd0 : blue_prod[15:8] + 8'd1;

      data_in.grey       = in_data.grey;
      data_in.brightness = in_data.brightness;
      if (in_data.full_sat) begin
         data_in.color = in_data.color;
      end else begin
         data_in.color.red   = red_dim + in_data.floor;
         data_in.color.green = green_dim + in_data.floor;
         data_in.color.blue  = blue_dim + in_data.floor;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance the valid bit when the stage may move
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the payload on an accepted request
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[hdl/hsv_value_stage.sv]
`default_nettype none

module hsv_value_stage
   import hsv_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output      logic      in_ready,
   input  wire shade_type in_data,
   output      logic      out_valid,
   input  wire logic      out_ready,
   output      rgb_type   out_data
);

   logic        valid_ff;
   rgb_type     data_ff;
   rgb_type     data_in;
   logic [7:0]  level;
   logic [15:0] red_prod;
   logic [15:0] green_prod;
   logic [15:0] blue_prod;

   // Scale by brightness; grey input passes brightness straight through
   always_comb begin
      level      = in_data.brightness;
      red_prod   = in_data.color.red * level;
      green_prod = in_data.color.green * level;
      blue_prod  = in_data.color.blue * level;
      if (in_data.grey) begin
         data_in = '{red: level, green: level, blue: level};
      end else if (level == MAX_CHAN) begin
         data_in = in_data.color;
      end else if (level == 8'd0) begin
         data_in = '{red: 8'd0, green: 8'd0, blue: 8'd0};
      end else begin
         data_in.red   = (in_data.color.red == 8'd0) ? 8'd0 : red_prod[15:8] + 8'd1;
         data_in.green = (in_data.color.green == 8'd0) ? 8'd0 : green_prod[15:8] + 8'd1;
         data_in.blue  = (in_data.color.blue == 8'd0) ? 8'd0 : blue_prod[15:8] + 8'd1;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance the valid bit when the output register may move
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the result on an accepted request
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[hdl/hsv_to_rgb_rainbow_unit.sv]
// Rainbow-map HSV to RGB converter, 8 bits per channel. It takes one pixel
// request per clock while the result side does not stall, and returns one
// RGB result per request, in order. The four register stages are: ramp
// scaling and the saturation square, the section color select,
// desaturation (one 8x8 multiplier per channel) and brightness scaling
// (one 8x8 multiplier per channel), whose register drives rsp_port.
// Each stage holds its pixel while the next one is full, so up to four
// pixels are in flight and a stall neither drops nor repeats any of them.
`default_nettype none

module hsv_to_rgb_rainbow_unit
   import hsv_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   hsv_req_if.sink    req_port,
   hsv_rsp_if.source  rsp_port
);

   logic      ramp_valid;
   logic      ramp_ready;
   ramp_type  ramp_data;
   logic      col_valid;
   logic      col_ready;
   color_type col_data;
   logic      shd_valid;
   logic      shd_ready;
   shade_type shd_data;
   rgb_type   out_data;

   hsv_ramp_stage u_ramp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_port.valid),
      .in_ready   (req_port.ready),
      .hue        (req_port.hue),
      .saturation (req_port.saturation),
      .brightness (req_port.brightness),
      .out_valid  (ramp_valid),
      .out_ready  (ramp_ready),
      .out_data   (ramp_data)
   );

   hsv_map_stage u_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ramp_valid),
      .in_ready  (ramp_ready),
      .in_data   (ramp_data),
      .out_valid (col_valid),
      .out_ready (col_ready),
      .out_data  (col_data)
   );

   hsv_desat_stage u_desat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (col_valid),
      .in_ready  (col_ready),
      .in_data   (col_data),
      .out_valid (shd_valid),
      .out_ready (shd_ready),
      .out_data  (shd_data)
   );

   hsv_value_stage u_value (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (shd_valid),
      .in_ready  (shd_ready),
      .in_data   (shd_data),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_data  (out_data)
   );

   // Drive the result channel
   assign rsp_port.red   = out_data.red;
   assign rsp_port.green = out_data.green;
   assign rsp_port.blue  = out_data.blue;

`ifndef SYNTHESIS
   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_port.valid)
      else $error("result valid after reset");

   // A stalled desaturated pixel holds in place
   a_shade_hold: assert property (@(posedge clock) disable iff (reset)
      (shd_valid && !shd_ready) |=> (shd_valid && $stable(shd_data)))
      else $error("desaturated pixel lost under stall");

   // Zero brightness always gives black
   a_black: assert property (@(posedge clock) disable iff (reset)
      (shd_valid && shd_ready && shd_data.brightness == 8'd0) |=>
      (rsp_port.red == 8'd0 && rsp_port.green == 8'd0 && rsp_port.blue == 8'd0))
      else $error("zero brightness not black");

   // A lit red channel never lands exactly on the floor after desaturation
   a_desat_lit: assert property (@(posedge clock) disable iff (reset)
      (col_valid && col_ready && !col_data.full_sat && !col_data.grey &&
       col_data.color.red != 8'd0) |=> (shd_data.color.red != $past(col_data.floor)))
      else $error("lit red channel collapsed to floor");
`endif

endmodule

`default_nettype wire

[dv/hsv_rainbow_checker.sv]
`timescale 1ns / 1ps

module hsv_rainbow_checker
   import hsv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_hue,
   input  logic [7:0] req_saturation,
   input  logic [7:0] req_brightness,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_red,
   input  logic [7:0] rsp_green,
   input  logic [7:0] rsp_blue,
   output int         mismatch_count,
   output int         pending_count
);

   rgb_type expected_rgb[$];

   // Scale one channel by the kept share of saturation; zero stays zero
   function automatic logic [7:0] desat_chan(logic [7:0] level, logic [7:0] keep);
      if (level == 8'd0)
         return 8'd0;
      return 8'((16'(level) * 16'(keep)) >> 8) + ((keep != 8'd0) ? 8'd1 : 8'd0);
   endfunction

   // Scale one channel by brightness; zero stays zero
   function automatic logic [7:0] dim_chan(logic [7:0] level, logic [7:0] bright);
      if (level == 8'd0)
         return 8'd0;
      return 8'((16'(level) * 16'(bright)) >> 8) + 8'd1;
   endfunction

   // Compute the RGB pixel the converter should return for one request
   function automatic rgb_type predict_rainbow(logic [7:0] hue, logic [7:0] sat,
                                               logic [7:0] bright);
      logic [7:0] ramp;
      logic [7:0] third;
      logic [7:0] two_thirds;
      logic [7:0] floor_lvl;
      logic [7:0] keep;
      rgb_type    pix;

      // Grey passes brightness straight through
      if (sat == 8'd0) begin
         pix.red   = bright;
         pix.green = bright;
         pix.blue  = bright;
         return pix;
      end

      ramp       = {hue[4:0], 3'b000};
      third      = 8'((16'(ramp) * 16'(THIRD_SCALE)) >> 8);
      two_thirds = 8'((16'(ramp) * 16'(TWO_THIRDS_SCALE)) >> 8);

      // Pick the section color from the top hue bits
      case (hue[7:5])
         SEC_RED:    pix = '{MAX_CHAN - third, third, 8'd0};
         SEC_ORANGE: pix = '{LEVEL_RISE_TOP, LEVEL_THIRD + third, 8'd0};
         SEC_YELLOW: pix = '{LEVEL_RISE_TOP - two_thirds, LEVEL_TWO_3RD + third, 8'd0};
         SEC_GREEN:  pix = '{8'd0, MAX_CHAN - third, third};
         SEC_AQUA:   pix = '{8'd0, LEVEL_RISE_TOP - two_thirds, LEVEL_THIRD + third};
         SEC_BLUE:   pix = '{third, 8'd0, MAX_CHAN - third};
         SEC_PURPLE: pix = '{LEVEL_THIRD + third, 8'd0, LEVEL_RISE_TOP - two_thirds};
         default:    pix = '{PINK_RED, 8'd0, PINK_BLUE};
      endcase

      // Desaturate: squared floor plus scaled nonzero channels, wrapping
      if (sat != MAX_CHAN) begin
         floor_lvl = MAX_CHAN - sat;
         floor_lvl = 8'((16'(floor_lvl) * 16'(floor_lvl)) >> 8) + 8'd1;
         keep      = MAX_CHAN - floor_lvl;
         pix.red   = desat_chan(pix.red, keep) + floor_lvl;
         pix.green = desat_chan(pix.green, keep) + floor_lvl;
         pix.blue  = desat_chan(pix.blue, keep) + floor_lvl;
      end

      // Apply brightness
      if (bright == 8'd0) begin
         pix = '{8'd0, 8'd0, 8'd0};
      end else if (bright != MAX_CHAN) begin
         pix.red   = dim_chan(pix.red, bright);
         pix.green = dim_chan(pix.green, bright);
         pix.blue  = dim_chan(pix.blue, bright);
      end
      return pix;
   endfunction

   assign pending_count = expected_rgb.size();

   initial mismatch_count = 0;

   // Record each accepted request and check each accepted result in order
   always @(posedge clock) begin
      rgb_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_rgb.push_back(predict_rainbow(req_hue, req_saturation,
                                                   req_brightness));
         if (rsp_valid && rsp_ready) begin
            if (expected_rgb.size() == 0) begin
               $error("unexpected result: red %0d green %0d blue %0d",
                      rsp_red, rsp_green, rsp_blue);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_rgb.pop_front();
               if (rsp_red !== want.red)
                  $error("red mismatch: expected %0d, got %0d", want.red, rsp_red);
               if (rsp_green !== want.green)
                  $error("green mismatch: expected %0d, got %0d", want.green, rsp_green);
               if (rsp_blue !== want.blue)
                  $error("blue mismatch: expected %0d, got %0d", want.blue, rsp_blue);
               if (rsp_red !== want.red || rsp_green !== want.green ||
                   rsp_blue !== want.blue)
                  mismatch_count <= mismatch_count + 1;
            end
         end
      end
   end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import hsv_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 12;

   logic clock;
   logic reset;
   int   cycle_count;
   int   stall_left;
   logic calm;
   int   mismatch_count;
   int   pending_count;

   hsv_req_if req_bus ();
   hsv_rsp_if rsp_bus ();

   hsv_to_rgb_rainbow_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   hsv_rainbow_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_hue        (req_bus.hue),
      .req_saturation (req_bus.saturation),
      .req_brightness (req_bus.brightness),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_red        (rsp_bus.red),
      .rsp_green      (rsp_bus.green),
      .rsp_blue       (rsp_bus.blue),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Idle length: mostly none or short, a few long
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 96)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Byte with extra weight on the ends of the range
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 11))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd254;
         3:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Stall the result side at random, except in calm stretches
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 25) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= gap_length();
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL hsv_to_rgb_rainbow_unit");
         $finish;
      end
   end

   // Present one pixel request and hold it until accepted
   task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                             input logic [7:0] bright);
      int gap;
      gap = calm ? 0 : gap_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.hue        <= hue;
      req_bus.saturation <= sat;
      req_bus.brightness <= bright;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   initial begin
      logic [7:0] sat_corner[4];
      logic [7:0] bright_corner[4];
      logic [7:0] hue;

      reset              = 1'b1;
      cycle_count        = 0;
      stall_left         = 0;
      calm               = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.hue        = 8'd0;
      req_bus.saturation = 8'd0;
      req_bus.brightness = 8'd0;
      rsp_bus.ready      = 1'b1;
      sat_corner    = '{8'd255, 8'd254, 8'd1, 8'd128};
      bright_corner = '{8'd255, 8'd1, 8'd254, 8'd77};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every section at both ends of its ramp, across saturation and brightness corners
      for (int sec = 0; sec < 8; sec++) begin
         hue = {3'(sec), 5'd0};
         send_pixel(hue, sat_corner[sec % 4], bright_corner[(sec + 1) % 4]);
         hue = {3'(sec), RAMP_MASK};
         send_pixel(hue, sat_corner[(sec + 2) % 4], bright_corner[sec % 4]);
      end

      // Grey, black and full-scale corners
      send_pixel(8'h55, 8'd0, 8'd200);
      send_pixel(8'hFF, 8'd0, 8'd0);
      send_pixel(8'h00, 8'd0, 8'd255);
      send_pixel(8'hAA, 8'd128, 8'd0);
      send_pixel(8'hFF, 8'd255, 8'd0);
      send_pixel(8'h3C, 8'd1, 8'd1);
      send_pixel(8'hC7, 8'd254, 8'd254);
      send_pixel(8'hFF, 8'd255, 8'd255);

      // Random pixels, with calm stretches now and then
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0)
            calm = ($urandom_range(0, 3) == 0);
         send_pixel(8'($urandom_range(0, 255)), pick_level(), pick_level());
      end
      req_bus.valid <= 1'b0;
      calm = 1'b0;

      // Drain outstanding results, then watch for strays
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("PASS hsv_to_rgb_rainbow_unit");
      else
         $display("FAIL hsv_to_rgb_rainbow_unit");
      $finish;
   end

endmodule

[sim.f]
hdl/hsv_pkg.sv
hdl/hsv_req_if.sv
hdl/hsv_rsp_if.sv
hdl/hsv_ramp_stage.sv
hdl/hsv_map_stage.sv
hdl/hsv_desat_stage.sv
hdl/hsv_value_stage.sv
hdl/hsv_to_rgb_rainbow_unit.sv
dv/hsv_rainbow_checker.sv
dv/tb.sv
